[sv/ffp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffp_pkg
// Word types, constants and digit-step functions for the flat pattern pipeline.
// ----------------------------------------------------------------------------
package ffp_pkg;

   localparam int          InWidth      = 24;
   localparam int          SqrtSteps    = 50;
   localparam int          DivSteps     = 50;
   localparam int          AngleRoot    = 25;
   localparam int          Depth        = SqrtSteps + DivSteps;
   localparam logic [24:0] FullTurnQ16  = 25'd23592960;

   typedef struct packed {
      logic [InWidth-1:0] first_diameter;
      logic [InWidth-1:0] second_diameter;
      logic [InWidth-1:0] cone_height;
      logic signed [15:0] piece_count;
   } req_type;

   typedef struct packed {
      logic [31:0] inner_radius;
      logic [31:0] outer_radius;
      logic [24:0] total_angle;
      logic [24:0] piece_angle;
      logic        count_fixed;
      logic        shape_error;
      logic        saturated;
   } rsp_type;

   typedef struct packed {
      logic [99:0] sh;
      logic [51:0] rem;
      logic [49:0] res;
   } unit_type;

   typedef struct packed {
      logic        fixed;
      logic        err;
      logic [14:0] count;
      logic [23:0] d;
      logic [50:0] q;
      logic [24:0] ttl;
      unit_type    ua;
      unit_type    ub;
      unit_type    uc;
   } stage_type;

   function automatic unit_type sqrt_step(unit_type u);
      logic [51:0] r;
      logic [51:0] trial;
      unit_type    o;
      r     = {u.rem[49:0], u.sh[99:98]};
      trial = {u.res[49:0], 2'b01};
      o.sh  = {u.sh[97:0], 2'b00};
      if (r >= trial) begin
         o.rem = r - trial;
         o.res = {u.res[48:0], 1'b1};
      end else begin
         o.rem = r;
         o.res = {u.res[48:0], 1'b0};
      end
      return o;
   endfunction

   function automatic unit_type div_step(unit_type u, logic [51:0] dv);
      logic [51:0] r;
      unit_type    o;
      r    = {u.rem[50:0], u.sh[99]};
      o.sh = {u.sh[98:0], 1'b0};
      if (r >= dv) begin
         o.rem = r - dv;
         o.res = {u.res[48:0], 1'b1};
      end else begin
         o.rem = r;
         o.res = {u.res[48:0], 1'b0};
      end
      return o;
   endfunction

endpackage

[sv/frustum_flat_pattern.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frustum_flat_pattern
// Flat development of a truncated cone: slant radii and sector angles.
// Throughput: one word per cycle while the pipeline is not stalled by rsp_ready;
// 5 product/sum stages, then 100 digit stages (ua and ub lanes: 50 root steps,
// then 50 quotient steps; uc lane: 50 quotient, 25 root, then 25 quotient steps).
// Reset clears all valid bits; no other state.
// ----------------------------------------------------------------------------
module frustum_flat_pattern (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ffp_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ffp_pkg::rsp_type rsp_word
);
   import ffp_pkg::*;

   logic        adv;
   logic [4:0]  pv_ff;
   logic        vld_ff [0:Depth-1];
   stage_type   st_ff  [0:Depth-1];

   logic        fixed1_ff, err1_ff;
   logic [14:0] count1_ff;
   logic [23:0] r1_ff, r2_ff, d1_ff;
   logic [24:0] ht_ff;

   logic        fixed2_ff, err2_ff;
   logic [14:0] count2_ff;
   logic [23:0] d2_ff;
   logic [49:0] htsq_ff;
   logic [47:0] dsq_ff, r1sq2_ff, r2sq2_ff;
   logic [48:0] ad2_ff;

   logic        fixed3_ff, err3_ff;
   logic [14:0] count3_ff;
   logic [23:0] d3_ff;
   logic [50:0] q3_ff;
   logic [47:0] r1sq3_ff, r2sq3_ff;
   logic [48:0] ad3_ff;

   logic        fixed4_ff, err4_ff;
   logic [14:0] count4_ff;
   logic [23:0] d4_ff;
   logic [50:0] q4_ff;
   logic [49:0] a_hh_ff, a_hl_ff, a_lh_ff, a_ll_ff;
   logic [49:0] b_hh_ff, b_hl_ff, b_lh_ff, b_ll_ff;
   logic [49:0] m_hh_ff, m_hl_ff, m_ll_ff;

   stage_type   st5_in, st5_ff;
   logic [98:0] n1_in, n2_in, m_in;
   logic [23:0] da, db;
   logic        neg_cnt;

   assign adv       = !vld_ff[Depth-1] || rsp_ready;
   assign req_ready = adv;
   assign da        = req_word.first_diameter;
   assign db        = req_word.second_diameter;
   assign neg_cnt   = req_word.piece_count[15] || (req_word.piece_count == 16'sd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= '0;
      end else if (adv) begin
         pv_ff <= {pv_ff[3:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fixed1_ff <= neg_cnt;
         err1_ff   <= (da == db) || (req_word.cone_height == '0);
         count1_ff <= neg_cnt ? 15'd1 : req_word.piece_count[14:0];
         r1_ff     <= (da < db) ? da : db;
         r2_ff     <= (da < db) ? db : da;
         d1_ff     <= (da < db) ? (db - da) : (da - db);
         ht_ff     <= {req_word.cone_height, 1'b0};

         fixed2_ff <= fixed1_ff;
         err2_ff   <= err1_ff;
         count2_ff <= count1_ff;
         d2_ff     <= d1_ff;
         htsq_ff   <= {25'b0, ht_ff} * {25'b0, ht_ff};
         dsq_ff    <= {24'b0, d1_ff} * {24'b0, d1_ff};
         r1sq2_ff  <= {24'b0, r1_ff} * {24'b0, r1_ff};
         r2sq2_ff  <= {24'b0, r2_ff} * {24'b0, r2_ff};
         ad2_ff    <= {24'b0, FullTurnQ16} * {25'b0, d1_ff};

         fixed3_ff <= fixed2_ff;
         err3_ff   <= err2_ff;
         count3_ff <= count2_ff;
         d3_ff     <= d2_ff;
         q3_ff     <= {1'b0, htsq_ff} + {3'b0, dsq_ff};
         r1sq3_ff  <= r1sq2_ff;
         r2sq3_ff  <= r2sq2_ff;
         ad3_ff    <= ad2_ff;

         fixed4_ff <= fixed3_ff;
         err4_ff   <= err3_ff;
         count4_ff <= count3_ff;
         d4_ff     <= d3_ff;
         q4_ff     <= q3_ff;
         a_hh_ff   <= {26'b0, r1sq3_ff[47:24]} * {24'b0, q3_ff[50:25]};
         a_hl_ff   <= {26'b0, r1sq3_ff[47:24]} * {25'b0, q3_ff[24:0]};
         a_lh_ff   <= {26'b0, r1sq3_ff[23:0]} * {24'b0, q3_ff[50:25]};
         a_ll_ff   <= {26'b0, r1sq3_ff[23:0]} * {25'b0, q3_ff[24:0]};
         b_hh_ff   <= {26'b0, r2sq3_ff[47:24]} * {24'b0, q3_ff[50:25]};
         b_hl_ff   <= {26'b0, r2sq3_ff[47:24]} * {25'b0, q3_ff[24:0]};
         b_lh_ff   <= {26'b0, r2sq3_ff[23:0]} * {24'b0, q3_ff[50:25]};
         b_ll_ff   <= {26'b0, r2sq3_ff[23:0]} * {25'b0, q3_ff[24:0]};
         m_hh_ff   <= {25'b0, ad3_ff[48:24]} * {25'b0, ad3_ff[48:24]};
         m_hl_ff   <= {25'b0, ad3_ff[48:24]} * {26'b0, ad3_ff[23:0]};
         m_ll_ff   <= {26'b0, ad3_ff[23:0]} * {26'b0, ad3_ff[23:0]};

         st5_ff    <= st5_in;
      end
   end

   always_comb begin
      n1_in = ({49'b0, a_hh_ff} << 49) + ({49'b0, a_hl_ff} << 24)
            + ({49'b0, a_lh_ff} << 25) + {49'b0, a_ll_ff};
      n2_in = ({49'b0, b_hh_ff} << 49) + ({49'b0, b_hl_ff} << 24)
            + ({49'b0, b_lh_ff} << 25) + {49'b0, b_ll_ff};
      m_in  = ({49'b0, m_hh_ff} << 48) + ({49'b0, m_hl_ff} << 25)
            + {49'b0, m_ll_ff};
      st5_in        = '0;
      st5_in.fixed  = fixed4_ff;
      st5_in.err    = err4_ff;
      st5_in.count  = count4_ff;
      st5_in.d      = d4_ff;
      st5_in.q      = q4_ff;
      st5_in.ua.sh  = {1'b0, n1_in};
      st5_in.ub.sh  = {1'b0, n2_in};
      st5_in.uc.rem = {4'b0, m_in[97:50]};
      st5_in.uc.sh  = {m_in[49:0], 50'b0};
   end

   for (genvar k = 0; k < Depth; k++) begin : g_stage
      stage_type cur, nxt_in;
      unit_type  ua0, ub0, uc0;
      logic      vprev;

      if (k == 0) begin : g_first
         assign cur   = st5_ff;
         assign vprev = pv_ff[4];
      end else begin : g_rest
         assign cur   = st_ff[k-1];
         assign vprev = vld_ff[k-1];
      end

      always_comb begin
         nxt_in = cur;
         ua0    = cur.ua;
         ub0    = cur.ub;
         uc0    = cur.uc;
         if (k < SqrtSteps) begin
            nxt_in.ua = sqrt_step(cur.ua);
            nxt_in.ub = sqrt_step(cur.ub);
            nxt_in.uc = div_step(cur.uc, {1'b0, cur.q});
         end else begin
            if (k == SqrtSteps) begin
               ua0 = '{sh: {cur.ua.res, 50'b0}, rem: '0, res: '0};
               ub0 = '{sh: {cur.ub.res, 50'b0}, rem: '0, res: '0};
               uc0 = '{sh: {cur.uc.res, 50'b0}, rem: '0, res: '0};
            end
            if (k == SqrtSteps + AngleRoot) begin
               uc0        = '{sh: {cur.uc.res[24:0], 75'b0}, rem: '0, res: '0};
               nxt_in.ttl = cur.uc.res[24:0];
            end
            nxt_in.ua = div_step(ua0, {28'b0, cur.d});
            nxt_in.ub = div_step(ub0, {28'b0, cur.d});
            if (k < SqrtSteps + AngleRoot) begin
               nxt_in.uc = sqrt_step(uc0);
            end else begin
               nxt_in.uc = div_step(uc0, {37'b0, cur.count});
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= vprev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            st_ff[k] <= nxt_in;
         end
      end
   end

   stage_type last;
   logic      sat_a, sat_b;

   assign last      = st_ff[Depth-1];
   assign sat_a     = last.ua.res[49:32] != '0;
   assign sat_b     = last.ub.res[49:32] != '0;
   assign rsp_valid = vld_ff[Depth-1];

   always_comb begin
      rsp_word             = '0;
      rsp_word.count_fixed = last.fixed;
      rsp_word.shape_error = last.err;
      if (!last.err) begin
         rsp_word.inner_radius = sat_a ? 32'hFFFF_FFFF : last.ua.res[31:0];
         rsp_word.outer_radius = sat_b ? 32'hFFFF_FFFF : last.ub.res[31:0];
         rsp_word.total_angle  = last.ttl;
         rsp_word.piece_angle  = last.uc.res[24:0];
         rsp_word.saturated    = sat_a || sat_b;
      end
   end

   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.shape_error |->
         !rsp_word.saturated && rsp_word.total_angle == '0 && rsp_word.outer_radius == '0)
      else $error("shape error word carries data");

   a_piece_le_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.piece_angle <= rsp_word.total_angle)
      else $error("piece angle above total angle");

   a_turn_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.total_angle <= FullTurnQ16)
      else $error("total angle above full turn");

   a_inner_le_outer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.inner_radius <= rsp_word.outer_radius)
      else $error("inner radius above outer radius");

endmodule
